// ----- hdl/e2d_pkg.sv -----
// ----------------------------------------------------------------------------
// e2d_pkg
// Shared types, constants and saturating fixed-point helpers for the
// 2D Epileptor forward Euler step core.
// ----------------------------------------------------------------------------
package e2d_pkg;

    // datapath format: signed Q8.24 in 32 bits
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 24;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int QUOT_WIDTH = PROD_WIDTH - FRAC_BITS;

    // configuration register widths
    localparam int INV_TAU_WIDTH = 31;
    localparam int STEP_WIDTH    = 25;
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [PROD_WIDTH-1:0] t_prod;

    localparam t_data DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_data FIX_ONE  = t_data'(64'd1 << FRAC_BITS);

    // register reset values
    localparam logic [INV_TAU_WIDTH-1:0] INV_TAU_RESET = INV_TAU_WIDTH'(1677722);
    localparam logic [STEP_WIDTH-1:0]    STEP_RESET    = STEP_WIDTH'(1677722);
    localparam t_data                    DRIVE_RESET   = t_data'(68786586);

    // configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_INV_TAU = 2'd0,
        CFG_STEP    = 2'd1,
        CFG_DRIVE   = 2'd2
    } t_cfg_idx;

    // configuration seen by the datapath
    typedef struct packed {
        logic [INV_TAU_WIDTH-1:0] inv_tau;
        logic [STEP_WIDTH-1:0]    step;
        t_data                    drive;
    } t_cfg;

    // value with its saturation flag
    typedef struct packed {
        t_data val;
        logic  sat;
    } t_sat;

    // saturating add
    function automatic t_sat sat_add(input t_data a, input t_data b);
        logic [DATA_WIDTH:0] s;
        t_sat                r;
        s     = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        r.sat = s[DATA_WIDTH] ^ s[DATA_WIDTH-1];
        if (r.sat) begin
            r.val = s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        end else begin
            r.val = s[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // saturating subtract
    function automatic t_sat sat_sub(input t_data a, input t_data b);
        logic [DATA_WIDTH:0] s;
        t_sat                r;
        s     = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        r.sat = s[DATA_WIDTH] ^ s[DATA_WIDTH-1];
        if (r.sat) begin
            r.val = s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        end else begin
            r.val = s[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // full product scaled back by floor, then saturated
    function automatic t_sat sat_prod(input t_prod p);
        logic [QUOT_WIDTH-1:0]           q;
        logic [QUOT_WIDTH-DATA_WIDTH:0]  top;
        t_sat                            r;
        q     = p[PROD_WIDTH-1:FRAC_BITS];
        top   = q[QUOT_WIDTH-1:DATA_WIDTH-1];
        r.sat = !((&top) || !(|top));
        if (r.sat) begin
            r.val = p[PROD_WIDTH-1] ? DATA_MIN : DATA_MAX;
        end else begin
            r.val = q[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/e2d_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// e2d_cfg_regs
// Configuration register file: decodes write transactions by index and
// holds the reciprocal time constant, step size and drive current.
// ----------------------------------------------------------------------------
module e2d_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [e2d_pkg::CFG_IDX_WIDTH-1:0]   i_addr,
    input  logic [e2d_pkg::DATA_WIDTH-1:0]      i_wr_data,
    output e2d_pkg::t_cfg                       o_cfg
);
    import e2d_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // write decode, out-of-range indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_addr)
                CFG_INV_TAU: n_cfg.inv_tau = i_wr_data[INV_TAU_WIDTH-1:0];
                CFG_STEP:    n_cfg.step    = i_wr_data[STEP_WIDTH-1:0];
                CFG_DRIVE:   n_cfg.drive   = i_wr_data;
                default:     n_cfg         = r_cfg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_tau <= INV_TAU_RESET;
            r_cfg.step    <= STEP_RESET;
            r_cfg.drive   <= DRIVE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/epileptor_2d_euler_step_core.sv -----
// ----------------------------------------------------------------------------
// epileptor_2d_euler_step_core
// One forward Euler step of the 2D Epileptor per node, signed Q8.24,
// saturating at every operation.
// ----------------------------------------------------------------------------
// Usage:
//   - command channel: a transaction is taken on each clock edge with start
//     high and busy low; busy is never raised, so a node may enter every cycle
//   - fields i_fast_var (x), i_slow_var (z), i_excitability (x0)
//   - result: o_next_fast, o_next_slow and o_overflow are shown for exactly
//     one cycle with o_valid high, once the node has left the last stage
//   - throughput is one node per cycle; the three dependent multiplies
//     (x*x, x^2*x, dt*dx) each sit in a register stage of their own and
//     the saturating adds fill the rest
//   - the receiver cannot stall, so the pipeline never holds
//   - configuration: i_cfg_wr_en writes i_cfg_wr_data into register
//     i_cfg_addr (0 inv tau, 1 step size, 2 drive current) at the next edge;
//     write only while no transaction is in flight
//   - reset (synchronous, active low) empties the pipeline and restores
//     the register defaults (1/tau 0.1, dt 0.1, I1 4.1)
// ----------------------------------------------------------------------------
module epileptor_2d_euler_step_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [e2d_pkg::DATA_WIDTH-1:0] i_fast_var,
    input  logic signed [e2d_pkg::DATA_WIDTH-1:0] i_slow_var,
    input  logic signed [e2d_pkg::DATA_WIDTH-1:0] i_excitability,
    input  logic                                i_cfg_wr_en,
    input  logic [e2d_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_addr,
    input  logic [e2d_pkg::DATA_WIDTH-1:0]      i_cfg_wr_data,
    output logic                                o_valid,
    output logic signed [e2d_pkg::DATA_WIDTH-1:0] o_next_fast,
    output logic signed [e2d_pkg::DATA_WIDTH-1:0] o_next_slow,
    output logic                                o_overflow
);
    import e2d_pkg::*;

    localparam int LATENCY = 6;

    t_cfg cfg;
    logic accept;
    logic [LATENCY-1:0] r_vld;

    e2d_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_addr    (i_cfg_addr),
        .i_wr_data (i_cfg_wr_data),
        .o_cfg     (cfg)
    );

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], accept};
        end
    end

    // ---------------- stage 1: x*x, and 4(x - x0) - z
    t_sat  n_s1_d, n_s1_q1, n_s1_q2, n_s1_w;
    t_data r_s1_x, r_s1_z, r_s1_w;
    t_prod r_s1_xx;
    logic  r_s1_ovf;

    always_comb begin
        n_s1_d  = sat_sub(i_fast_var, i_excitability);
        n_s1_q1 = sat_add(n_s1_d.val, n_s1_d.val);
        n_s1_q2 = sat_add(n_s1_q1.val, n_s1_q1.val);
        n_s1_w  = sat_sub(n_s1_q2.val, i_slow_var);
    end

    always_ff @(posedge i_clk) begin
        r_s1_x   <= i_fast_var;
        r_s1_z   <= i_slow_var;
        r_s1_xx  <= i_fast_var * i_fast_var;
        r_s1_w   <= n_s1_w.val;
        r_s1_ovf <= n_s1_d.sat | n_s1_q1.sat | n_s1_q2.sat | n_s1_w.sat;
    end

    // ---------------- stage 2: x2, x2*x and inv_tau*w
    t_sat  n_s2_x2;
    t_data inv_tau_s;
    t_data r_s2_x, r_s2_z, r_s2_x2;
    t_prod r_s2_x3p, r_s2_dzp;
    logic  r_s2_ovf;

    assign n_s2_x2   = sat_prod(r_s1_xx);
    assign inv_tau_s = {{(DATA_WIDTH-INV_TAU_WIDTH){1'b0}}, cfg.inv_tau};

    always_ff @(posedge i_clk) begin
        r_s2_x   <= r_s1_x;
        r_s2_z   <= r_s1_z;
        r_s2_x2  <= n_s2_x2.val;
        r_s2_x3p <= n_s2_x2.val * r_s1_x;
        r_s2_dzp <= inv_tau_s * r_s1_w;
        r_s2_ovf <= r_s1_ovf | n_s2_x2.sat;
    end

    // ---------------- stage 3: x3, dz, 1 - x3 and 2*x2
    t_sat  n_s3_x3, n_s3_dz, n_s3_a, n_s3_b;
    t_data r_s3_x, r_s3_z, r_s3_a, r_s3_b, r_s3_dz;
    logic  r_s3_ovf;

    always_comb begin
        n_s3_x3 = sat_prod(r_s2_x3p);
        n_s3_dz = sat_prod(r_s2_dzp);
        n_s3_a  = sat_sub(FIX_ONE, n_s3_x3.val);
        n_s3_b  = sat_add(r_s2_x2, r_s2_x2);
    end

    always_ff @(posedge i_clk) begin
        r_s3_x   <= r_s2_x;
        r_s3_z   <= r_s2_z;
        r_s3_a   <= n_s3_a.val;
        r_s3_b   <= n_s3_b.val;
        r_s3_dz  <= n_s3_dz.val;
        r_s3_ovf <= r_s2_ovf | n_s3_x3.sat | n_s3_dz.sat | n_s3_a.sat | n_s3_b.sat;
    end

    // ---------------- stage 4: (1 - x3 - 2x2) - z
    t_sat  n_s4_t1, n_s4_t2;
    t_data r_s4_x, r_s4_z, r_s4_t, r_s4_dz;
    logic  r_s4_ovf;

    always_comb begin
        n_s4_t1 = sat_sub(r_s3_a, r_s3_b);
        n_s4_t2 = sat_sub(n_s4_t1.val, r_s3_z);
    end

    always_ff @(posedge i_clk) begin
        r_s4_x   <= r_s3_x;
        r_s4_z   <= r_s3_z;
        r_s4_t   <= n_s4_t2.val;
        r_s4_dz  <= r_s3_dz;
        r_s4_ovf <= r_s3_ovf | n_s4_t1.sat | n_s4_t2.sat;
    end

    // ---------------- stage 5: add drive current, scale both by dt
    t_sat  n_s5_dx;
    t_data step_s;
    t_data r_s5_x, r_s5_z;
    t_prod r_s5_fxp, r_s5_szp;
    logic  r_s5_ovf;

    assign n_s5_dx = sat_add(r_s4_t, cfg.drive);
    assign step_s  = {{(DATA_WIDTH-STEP_WIDTH){1'b0}}, cfg.step};

    always_ff @(posedge i_clk) begin
        r_s5_x   <= r_s4_x;
        r_s5_z   <= r_s4_z;
        r_s5_fxp <= step_s * n_s5_dx.val;
        r_s5_szp <= step_s * r_s4_dz;
        r_s5_ovf <= r_s4_ovf | n_s5_dx.sat;
    end

    // ---------------- stage 6: state update into the output register
    t_sat  n_s6_fx, n_s6_sz, n_s6_nx, n_s6_nz;
    t_data r_next_fast, r_next_slow;
    logic  r_overflow;

    always_comb begin
        n_s6_fx = sat_prod(r_s5_fxp);
        n_s6_sz = sat_prod(r_s5_szp);
        n_s6_nx = sat_add(r_s5_x, n_s6_fx.val);
        n_s6_nz = sat_add(r_s5_z, n_s6_sz.val);
    end

    always_ff @(posedge i_clk) begin
        r_next_fast <= n_s6_nx.val;
        r_next_slow <= n_s6_nz.val;
        r_overflow  <= r_s5_ovf | n_s6_fx.sat | n_s6_sz.sat | n_s6_nx.sat | n_s6_nz.sat;
    end

    assign o_valid     = r_vld[LATENCY-1];
    assign o_next_fast = r_next_fast;
    assign o_next_slow = r_next_slow;
    assign o_overflow  = r_overflow;

    // ---------------- assertions
    // every accepted transaction comes out after the fixed latency
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("result strobe missing after pipeline latency");

    // reset empties the pipeline
    a_reset_flush : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // a saturation in the first stage reaches the overflow flag
    a_ovf_carry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && r_s1_ovf) |-> ##(LATENCY-1) (o_valid && o_overflow))
        else $error("early saturation lost before output");

    // a strobe only follows an accepted transaction
    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !$past(accept)) |-> 1'b0)
        else $error("pipeline entry without a transaction");

endmodule
